FILE: sv/assert_macros.svh
// Assertion macros used by the RTL of the cache block.
// Checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Condition that must never be true on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

FILE: sv/salwc_pkg.sv
// Package for the set associative write-back LRU cache tracer.
// Types, geometry constants and transfer codes; no dependencies.
package salwc_pkg;

   localparam int LINES      = 256;
   localparam int LINE_IDX_W = 8;
   localparam int MAX_WAYS   = 4;    // also the number of memory banks
   localparam int LANE_W     = 2;
   localparam int ROWS       = LINES / MAX_WAYS;
   localparam int ROW_W      = 6;
   localparam int ADDR_W     = 16;
   localparam int TAG_W      = 16;
   localparam int SET_W      = 6;
   localparam int CNT_W      = 9;
   localparam int MAX_BLOCK_LOG2 = 8;
   localparam int MAX_SETS_LOG2  = 6;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_WORDS_LOG2 = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETS_LOG2        = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAYS             = 2'd2;

   // transfer kinds
   localparam logic [2:0] XFER_CACHE_TO_CPU = 3'd0;
   localparam logic [2:0] XFER_CPU_TO_CACHE = 3'd1;
   localparam logic [2:0] XFER_MEM_TO_CACHE = 3'd2;
   localparam logic [2:0] XFER_CACHE_TO_MEM = 3'd3;
   localparam logic [2:0] XFER_DISCARD      = 3'd4;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef struct packed {
      logic              command;
      logic [ADDR_W-1:0] word_address;
   } req_type;

   typedef struct packed {
      logic [2:0]        transfer_kind;
      logic [ADDR_W-1:0] start_address;
      logic [CNT_W-1:0]  word_count;
      logic              last_record;
   } rsp_type;

   // per-line state held in memory (valid bits live in flops)
   typedef struct packed {
      logic             dirty;
      logic [TAG_W-1:0] tag;
      logic [1:0]       age;
   } line_type;

endpackage

FILE: sv/set_assoc_lru_writeback_cache_top.sv
// Set associative write-back LRU cache tracer, top level.
// Records: after the request transaction come set read (ST_READ) and lookup (ST_LOOKUP); the
//   records are then registered in the output queue and offered one per cycle while rsp_ready is
//   high. A new request is taken only in ST_IDLE, and lookup waits for an empty output queue.
// Reset: synchronous, active high; clears valid bits, FSM, output queue, config to defaults.
//   Tag, dirty and age memories are not cleared; they are written on every fill.
`include "assert_macros.svh"

module set_assoc_lru_writeback_cache_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  salwc_pkg::req_type                    req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output salwc_pkg::rsp_type                    rsp_payload,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [salwc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [salwc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import salwc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOOKUP
   } state_type;

   // ------------------------------------------------------------------
   // Configuration registers, raw as written; clamped on use.
   // ------------------------------------------------------------------
   logic [3:0] cfg_block_log2_ff;
   logic [2:0] cfg_sets_log2_ff;
   logic [2:0] cfg_ways_ff;

   logic [3:0] eff_b;
   logic [2:0] eff_s;
   logic [2:0] eff_w;

   assign eff_b = (cfg_block_log2_ff > 4'(MAX_BLOCK_LOG2)) ? 4'(MAX_BLOCK_LOG2)
                                                           : cfg_block_log2_ff;
   // 2^s * ways never exceeds the 256 lines once s is at most 6 and ways at most 4
   assign eff_s = (cfg_sets_log2_ff > 3'(MAX_SETS_LOG2)) ? 3'(MAX_SETS_LOG2)
                                                         : cfg_sets_log2_ff;
   always_comb begin
      if (cfg_ways_ff == 3'd0) begin
         eff_w = 3'd1;
      end else if (cfg_ways_ff > 3'(MAX_WAYS)) begin
         eff_w = 3'(MAX_WAYS);
      end else begin
         eff_w = cfg_ways_ff;
      end
   end

   // ------------------------------------------------------------------
   // Address split at accept time
   // ------------------------------------------------------------------
   logic [ADDR_W-1:0]     addr_shift;
   logic [SET_W-1:0]      set_mask;
   logic [SET_W-1:0]      set_in;
   logic [4:0]            bs_in;
   logic [TAG_W-1:0]      tag_in;
   logic [LINE_IDX_W-1:0] base_in;

   assign addr_shift = req_payload.word_address >> eff_b;
   assign set_mask   = SET_W'((7'd1 << eff_s) - 7'd1);
   assign set_in     = addr_shift[SET_W-1:0] & set_mask;
   assign bs_in      = 5'(eff_b) + 5'(eff_s);
   assign tag_in     = TAG_W'(req_payload.word_address >> bs_in);
   // line index of way 0 of the set; at most 252
   assign base_in    = LINE_IDX_W'({2'b00, set_in} * {5'b00000, eff_w});

   // ------------------------------------------------------------------
   // Transaction registers
   // ------------------------------------------------------------------
   state_type             state_ff;
   logic                  cmd_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [SET_W-1:0]      set_ff;
   logic [TAG_W-1:0]      tag_ff;
   logic [LINE_IDX_W-1:0] base_ff;
   logic [3:0]            b_ff;
   logic [4:0]            bs_ff;
   logic [2:0]            w_ff;

   // output queue: up to three records per transaction
   rsp_type    out_rec_ff [3];
   logic [1:0] out_head_ff;
   logic [1:0] out_cnt_ff;

   // ------------------------------------------------------------------
   // Banked line memory. Line i sits in bank i%4, row i/4, so the up to
   // four consecutive lines of a set always land in distinct banks.
   // ------------------------------------------------------------------
   line_type             rd_data_ff  [MAX_WAYS];
   logic [LANE_W-1:0]    bank_lane   [MAX_WAYS];
   logic [ROW_W-1:0]     bank_row    [MAX_WAYS];
   logic                 bank_we     [MAX_WAYS];
   line_type             bank_wdata  [MAX_WAYS];

   logic                 line_valid_ff [LINES];
   logic [MAX_WAYS-1:0]  lane_vld_ff;

   always_comb begin
      logic [LINE_IDX_W-1:0] idx;
      for (int k = 0; k < MAX_WAYS; k++) begin
         bank_lane[k] = LANE_W'(k) - base_ff[LANE_W-1:0];
         idx          = base_ff + LINE_IDX_W'(bank_lane[k]);
         bank_row[k]  = idx[LINE_IDX_W-1:LANE_W];
      end
   end

   for (genvar k = 0; k < MAX_WAYS; k++) begin : g_bank
      line_type line_mem [ROWS];

      always_ff @(posedge clock) begin
         if (state_ff == ST_READ) begin
            rd_data_ff[k] <= line_mem[bank_row[k]];
         end
         if (bank_we[k]) begin
            line_mem[bank_row[k]] <= bank_wdata[k];
         end
      end
   end

   // ------------------------------------------------------------------
   // Lookup, victim choice, LRU update and trace records
   // ------------------------------------------------------------------
   line_type          lane_line [MAX_WAYS];
   logic              lane_use  [MAX_WAYS];
   line_type          new_line  [MAX_WAYS];
   logic              hit;
   logic [LANE_W-1:0] way;
   logic              victim_valid;
   rsp_type           rec_in    [3];
   logic [1:0]        rec_cnt_in;
   logic              lookup_go;

   assign lookup_go = (state_ff == ST_LOOKUP) && (out_cnt_ff == 2'd0);

   always_comb begin
      logic              found;
      logic [LANE_W-1:0] hit_way;
      logic [LANE_W-1:0] inv_way;
      logic [LANE_W-1:0] lru_way;
      logic [1:0]        best;
      logic [2:0]        thr;
      logic [8:0]        block;
      logic [ADDR_W-1:0] old_addr;
      logic [ADDR_W-1:0] aligned;
      rsp_type           evict_rec;
      rsp_type           fill_rec;
      rsp_type           word_rec;

      hit     = 1'b0;
      hit_way = '0;
      found   = 1'b0;
      inv_way = '0;
      lru_way = '0;
      best    = 2'd0;
      for (int j = 0; j < MAX_WAYS; j++) begin
         lane_line[j] = rd_data_ff[base_ff[LANE_W-1:0] + LANE_W'(j)];
         lane_use[j]  = (3'(j) < w_ff);
      end
      for (int j = MAX_WAYS - 1; j >= 0; j--) begin
         if (lane_use[j] && lane_vld_ff[j] && (lane_line[j].tag == tag_ff)) begin
            hit     = 1'b1;
            hit_way = LANE_W'(j);
         end
         if (lane_use[j] && !lane_vld_ff[j]) begin
            found   = 1'b1;
            inv_way = LANE_W'(j);
         end
      end
      // oldest way, lowest index on ties
      for (int j = 0; j < MAX_WAYS; j++) begin
         if (lane_use[j] && (lane_line[j].age > best)) begin
            best    = lane_line[j].age;
            lru_way = LANE_W'(j);
         end
      end

      if (hit) begin
         way = hit_way;
      end else if (found) begin
         way = inv_way;
      end else begin
         way = lru_way;
      end
      victim_valid = !hit && lane_vld_ff[way];

      thr = lane_vld_ff[way] ? {1'b0, lane_line[way].age} : 3'd4;
      for (int j = 0; j < MAX_WAYS; j++) begin
         new_line[j] = lane_line[j];
         if ((LANE_W'(j) != way) && lane_vld_ff[j] && ({1'b0, lane_line[j].age} < thr)
             && (lane_line[j].age != 2'd3)) begin
            new_line[j].age = lane_line[j].age + 2'd1;
         end
      end
      new_line[way].age   = 2'd0;
      new_line[way].tag   = tag_ff;
      new_line[way].dirty = hit ? (lane_line[way].dirty | cmd_ff) : cmd_ff;

      block    = 9'd1 << b_ff;
      aligned  = addr_ff & (16'hFFFF << b_ff);
      old_addr = (lane_line[way].tag << bs_ff) | ({10'b0, set_ff} << b_ff);

      evict_rec.transfer_kind = lane_line[way].dirty ? XFER_CACHE_TO_MEM : XFER_DISCARD;
      evict_rec.start_address = old_addr;
      evict_rec.word_count    = block;
      evict_rec.last_record   = 1'b0;

      fill_rec.transfer_kind  = XFER_MEM_TO_CACHE;
      fill_rec.start_address  = aligned;
      fill_rec.word_count     = block;
      fill_rec.last_record    = 1'b0;

      word_rec.transfer_kind  = (cmd_ff == CMD_WRITE) ? XFER_CPU_TO_CACHE : XFER_CACHE_TO_CPU;
      word_rec.start_address  = addr_ff;
      word_rec.word_count     = 9'd1;
      word_rec.last_record    = 1'b1;

      if (hit) begin
         rec_in[0]  = word_rec;
         rec_in[1]  = word_rec;
         rec_in[2]  = word_rec;
         rec_cnt_in = 2'd1;
      end else if (victim_valid) begin
         rec_in[0]  = evict_rec;
         rec_in[1]  = fill_rec;
         rec_in[2]  = word_rec;
         rec_cnt_in = 2'd3;
      end else begin
         rec_in[0]  = fill_rec;
         rec_in[1]  = word_rec;
         rec_in[2]  = word_rec;
         rec_cnt_in = 2'd2;
      end

      for (int k = 0; k < MAX_WAYS; k++) begin
         bank_we[k]    = lookup_go && lane_use[bank_lane[k]];
         bank_wdata[k] = new_line[bank_lane[k]];
      end
   end

   // ------------------------------------------------------------------
   // Valid bits: flops, cleared at reset; set on every fill
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINES; i++) begin
            line_valid_ff[i] <= 1'b0;
         end
      end else if (lookup_go && !hit) begin
         line_valid_ff[base_ff + LINE_IDX_W'(way)] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         for (int j = 0; j < MAX_WAYS; j++) begin
            lane_vld_ff[j] <= line_valid_ff[base_ff + LINE_IDX_W'(j)];
         end
      end
   end

   // ------------------------------------------------------------------
   // Handshakes
   // ------------------------------------------------------------------
   assign req_ready   = (state_ff == ST_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = (out_cnt_ff != 2'd0);
   assign rsp_payload = out_rec_ff[out_head_ff];

   // ------------------------------------------------------------------
   // FSM, config and output queue
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         out_head_ff       <= 2'd0;
         out_cnt_ff        <= 2'd0;
         cfg_block_log2_ff <= 4'd2;
         cfg_sets_log2_ff  <= 3'd0;
         cfg_ways_ff       <= 3'd1;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_BLOCK_WORDS_LOG2: cfg_block_log2_ff <= csr_wdata;
               CSR_SETS_LOG2:        cfg_sets_log2_ff  <= csr_wdata[2:0];
               CSR_WAYS:             cfg_ways_ff       <= csr_wdata[2:0];
               default: ;
            endcase
         end

         if (rsp_valid && rsp_ready) begin
            out_head_ff <= out_head_ff + 2'd1;
            out_cnt_ff  <= out_cnt_ff - 2'd1;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= req_payload.command;
                  addr_ff  <= req_payload.word_address;
                  set_ff   <= set_in;
                  tag_ff   <= tag_in;
                  base_ff  <= base_in;
                  b_ff     <= eff_b;
                  bs_ff    <= bs_in;
                  w_ff     <= eff_w;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_LOOKUP;
            end
            ST_LOOKUP: begin
               // wait until the previous transaction's records are gone
               if (out_cnt_ff == 2'd0) begin
                  out_rec_ff[0] <= rec_in[0];
                  out_rec_ff[1] <= rec_in[1];
                  out_rec_ff[2] <= rec_in[2];
                  out_head_ff   <= 2'd0;
                  out_cnt_ff    <= rec_cnt_in;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   `ASSERT_CLK(a_accept_to_read, clock, reset, (req_valid && req_ready) |=> (state_ff == ST_READ))
   `ASSERT_CLK(a_lookup_emits, clock, reset, lookup_go |=> (out_cnt_ff != 2'd0))
   `ASSERT_CLK(a_last_on_final, clock, reset, rsp_valid |-> (rsp_payload.last_record == (out_cnt_ff == 2'd1)))
   `ASSERT_NEVER(a_queue_bound, clock, reset, (out_cnt_ff == 2'd3) && (out_head_ff != 2'd0))

endmodule

FILE: sim/set_assoc_lru_writeback_cache_top_tb.sv
// Self-checking testbench for the set associative write-back LRU cache tracer.
// Depends on salwc_pkg and set_assoc_lru_writeback_cache_top; reads no files.
`timescale 1ns / 100ps

module set_assoc_lru_writeback_cache_top_tb;
   import salwc_pkg::*;

   localparam int unsigned AGE_MAX        = 3;
   localparam int unsigned ITEMS_PER_PHASE = 44;
   localparam int unsigned PHASES         = 8;
   // index 3 decodes to no register; a write there must change nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_REGISTER = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   set_assoc_lru_writeback_cache_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // Shadow copy of the cache: configuration as written, plus the per-line
   // valid / dirty / tag / age state. Tags of never-filled lines are never
   // looked at, since a tag is only read behind a set valid bit.
   // ------------------------------------------------------------------
   logic [3:0]        cfg_block_log2 = 4'd2;
   logic [2:0]        cfg_sets_log2  = 3'd0;
   logic [2:0]        cfg_ways       = 3'd1;
   logic              line_valid [LINES];
   logic              line_dirty [LINES];
   logic [TAG_W-1:0]  line_tag   [LINES];
   logic [1:0]        line_age   [LINES];

   rsp_type           trace_queue [$];    // records still owed by the block
   rsp_type           want;
   logic [ADDR_W-1:0] hot_addrs [8];      // working set of the current phase

   bit                steady = 1'b0;      // no idling on either side while set
   int unsigned       accesses_sent  = 0;
   int unsigned       records_seen   = 0;
   int unsigned       mismatch_count = 0;
   int unsigned       csr_writes     = 0;

   initial begin
      for (int i = 0; i < LINES; i++) begin
         line_valid[i] = 1'b0;
         line_dirty[i] = 1'b0;
         line_tag[i]   = '0;
         line_age[i]   = 2'd0;
      end
   end

   // Geometry actually in use: block size capped at 256 words, ways forced
   // into 1..4, sets shrunk until they fit both the set limit and the 256 lines.
   function automatic void effective_geometry(output int unsigned b, output int unsigned s,
                                              output int unsigned w);
      b = (cfg_block_log2 > MAX_BLOCK_LOG2) ? MAX_BLOCK_LOG2 : cfg_block_log2;
      w = cfg_ways;
      if (w < 1) w = 1;
      if (w > MAX_WAYS) w = MAX_WAYS;
      s = cfg_sets_log2;
      while (s > 0 && ((1 << s) > (1 << MAX_SETS_LOG2) || (1 << s) * w > LINES))
         s--;
   endfunction

   function automatic void push_record(logic [2:0] kind, logic [ADDR_W-1:0] start,
                                       logic [CNT_W-1:0] count, logic last);
      rsp_type rec;
      rec.transfer_kind = kind;
      rec.start_address = start;
      rec.word_count    = count;
      rec.last_record   = last;
      trace_queue.push_back(rec);
   endfunction

   // Make one way the youngest of its set. Valid ways younger than it age by
   // one (all valid ways when it was invalid), saturating at AGE_MAX.
   function automatic void make_youngest(int unsigned base, int unsigned w, int unsigned way);
      int unsigned thr;
      thr = line_valid[base + way] ? line_age[base + way] : AGE_MAX + 1;
      for (int unsigned j = 0; j < w; j++) begin
         if (j != way && line_valid[base + j] && line_age[base + j] < thr &&
             line_age[base + j] < AGE_MAX)
            line_age[base + j] = line_age[base + j] + 2'd1;
      end
      line_age[base + way] = 2'd0;
   endfunction

   // Works out the trace one access produces and updates the shadow state.
   function automatic void predict_access(logic cmd, logic [ADDR_W-1:0] addr);
      int unsigned       b, s, w, set_idx, base, way, best;
      logic [TAG_W-1:0]  tag;
      logic [ADDR_W-1:0] aligned;
      logic [CNT_W-1:0]  blk_words;
      logic [31:0]       victim_addr;
      bit                hit, found;
      effective_geometry(b, s, w);
      set_idx   = (addr >> b) & ((1 << s) - 1);
      tag       = TAG_W'(addr >> (b + s));
      blk_words = CNT_W'(1 << b);
      aligned   = addr & ~ADDR_W'((1 << b) - 1);
      base      = set_idx * w;
      hit       = 1'b0;
      way       = 0;
      for (int unsigned j = 0; j < w; j++) begin
         if (!hit && line_valid[base + j] && line_tag[base + j] == tag) begin
            hit = 1'b1;
            way = j;
         end
      end
      if (!hit) begin
         found = 1'b0;
         for (int unsigned j = 0; j < w; j++) begin
            if (!found && !line_valid[base + j]) begin
               found = 1'b1;
               way   = j;
            end
         end
         if (!found) begin
            // oldest way wins, lowest index on ties
            best = 0;
            way  = 0;
            for (int unsigned j = 0; j < w; j++) begin
               if (line_age[base + j] > best) begin
                  best = line_age[base + j];
                  way  = j;
               end
            end
         end
         if (line_valid[base + way]) begin
            // victim address comes from the stored tag and today's set index
            victim_addr = (32'(line_tag[base + way]) << (b + s)) | (set_idx << b);
            push_record(line_dirty[base + way] ? XFER_CACHE_TO_MEM : XFER_DISCARD,
                        ADDR_W'(victim_addr), blk_words, 1'b0);
         end
         make_youngest(base, w, way);
         line_valid[base + way] = 1'b1;
         line_dirty[base + way] = 1'b0;
         line_tag[base + way]   = tag;
         push_record(XFER_MEM_TO_CACHE, aligned, blk_words, 1'b0);
      end else begin
         make_youngest(base, w, way);
      end
      if (cmd == CMD_WRITE)
         line_dirty[base + way] = 1'b1;
      push_record(cmd == CMD_WRITE ? XFER_CPU_TO_CACHE : XFER_CACHE_TO_CPU, addr,
                  CNT_W'(1), 1'b1);
   endfunction

   // Idle gap length: mostly none or short, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ------------------------------------------------------------------
   // Driving helpers. Inputs move on the falling edge; handshakes are
   // sampled on the rising edge.
   // ------------------------------------------------------------------
   task automatic send_access(input logic cmd, input logic [ADDR_W-1:0] addr);
      int unsigned gap;
      req_type     item;
      gap = pick_gap();
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      item.command      = cmd;
      item.word_address = addr;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_access(cmd, addr);
      accesses_sent++;
   endtask

   // Stop offering accesses and wait until every owed record has come out.
   task automatic drain_trace();
      @(negedge clock);
      req_valid <= 1'b0;
      while (trace_queue.size() != 0) @(posedge clock);
   endtask

   // Register write; only issued with the block idle.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_BLOCK_WORDS_LOG2: cfg_block_log2 = value;
         CSR_SETS_LOG2:        cfg_sets_log2  = value[2:0];
         CSR_WAYS:             cfg_ways       = value[2:0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_geometry(input logic [3:0] blk, input logic [3:0] sets,
                               input logic [3:0] ways);
      write_csr(CSR_BLOCK_WORDS_LOG2, blk);
      write_csr(CSR_SETS_LOG2, sets);
      write_csr(CSR_WAYS, ways);
   endtask

   // ------------------------------------------------------------------
   // Result side: random back-pressure, and a checker that pops the oldest
   // owed record on every rsp transaction.
   // ------------------------------------------------------------------
   initial begin
      int unsigned n;
      @(negedge clock);
      forever begin
         n = pick_gap();
         if (n != 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   function automatic void report_mismatch(string what, rsp_type exp_rec, rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: expected kind %0d addr %h count %0d last %0d, got kind %0d addr %h count %0d last %0d",
                  $realtime, what, exp_rec.transfer_kind, exp_rec.start_address,
                  exp_rec.word_count, exp_rec.last_record, got.transfer_kind,
                  got.start_address, got.word_count, got.last_record);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         records_seen++;
         if (trace_queue.size() == 0) begin
            report_mismatch("record with nothing owed", '0, rsp_payload);
         end else begin
            want = trace_queue.pop_front();
            if (rsp_payload.transfer_kind !== want.transfer_kind ||
                rsp_payload.start_address !== want.start_address ||
                rsp_payload.word_count    !== want.word_count    ||
                rsp_payload.last_record   !== want.last_record)
               report_mismatch("trace record mismatch", want, rsp_payload);
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset geometry (4-word blocks, one set, direct mapped): fill, read and
   // write hits, dirty writeback, clean discard, address extremes.
   task automatic test_direct_mapped_defaults();
      send_access(CMD_READ,  16'h0000);
      send_access(CMD_READ,  16'h0003);
      send_access(CMD_WRITE, 16'h0001);
      send_access(CMD_READ,  16'h0004);   // dirty line goes back to memory
      send_access(CMD_WRITE, 16'hFFFF);   // clean line dropped
      send_access(CMD_READ,  16'h8000);   // dirty top block written back
   endtask

   // One set of four one-word ways: fills into invalid ways, hits that
   // reorder the ages, then misses that must evict the oldest way.
   task automatic test_lru_four_ways();
      drain_trace();
      set_geometry(4'd0, 4'd0, 4'd4);
      send_access(CMD_READ,  16'h0001);
      send_access(CMD_READ,  16'h0002);
      send_access(CMD_READ,  16'h0003);
      send_access(CMD_READ,  16'h0004);
      send_access(CMD_WRITE, 16'h0002);
      send_access(CMD_READ,  16'h0001);
      send_access(CMD_READ,  16'h0005);
      send_access(CMD_READ,  16'h0006);
      send_access(CMD_WRITE, 16'h0007);
      send_access(CMD_READ,  16'h0008);
   endtask

   // Out-of-range settings: block size above 256 words, sets above the
   // limit, ways above four, and a write to an index with no register.
   task automatic test_clamped_settings();
      drain_trace();
      set_geometry(4'd15, 4'd7, 4'd7);
      write_csr(CSR_NO_REGISTER, 4'hF);
      send_access(CMD_READ,  16'h0000);
      send_access(CMD_WRITE, 16'h4000);
      send_access(CMD_READ,  16'hC0FF);
      send_access(CMD_WRITE, 16'hFFFF);
      send_access(CMD_READ,  16'h0100);
   endtask

   // Line state survives a geometry change and is read under the new one;
   // writeback addresses are rebuilt from the old tag and the new set.
   task automatic test_geometry_change();
      drain_trace();
      set_geometry(4'd0, 4'd0, 4'd1);
      send_access(CMD_READ,  16'h1234);
      send_access(CMD_WRITE, 16'h1235);
   endtask

   // Random accesses across several geometries. Most go to a small working
   // set per phase so that hits, dirty lines and evictions stay frequent.
   task automatic test_random_phases();
      int unsigned       b, s, w, sel;
      logic [3:0]        blk, sets, ways;
      logic [ADDR_W-1:0] addr;
      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         drain_trace();
         case (phase)
            0: begin blk = 4'd2;  sets = 4'd0; ways = 4'd1;  end
            1: begin blk = 4'd0;  sets = 4'd0; ways = 4'd4;  end
            2: begin blk = 4'd8;  sets = 4'd6; ways = 4'd4;  end
            3: begin blk = 4'd15; sets = 4'd7; ways = 4'd0;  end
            4: begin blk = 4'd3;  sets = 4'd2; ways = 4'd2;  end
            5: begin blk = 4'd1;  sets = 4'd4; ways = 4'd3;  end
            6: begin blk = 4'd9;  sets = 4'd5; ways = 4'd5;  end
            default: begin blk = 4'd4; sets = 4'd1; ways = 4'hA; end
         endcase
         set_geometry(blk, sets, ways);
         steady = (phase == 1 || phase == 5);
         effective_geometry(b, s, w);
         // few tags over two sets: more lines than ways, so evictions happen
         foreach (hot_addrs[i])
            hot_addrs[i] = ADDR_W'(($urandom_range(0, 5) << (b + s)) |
                                   ($urandom_range(0, 1) << b));
         for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 50)
               addr = hot_addrs[$urandom_range(0, 7)] | ADDR_W'($urandom & ((1 << b) - 1));
            else if (sel < 70)
               addr = hot_addrs[$urandom_range(0, 7)];
            else
               addr = ADDR_W'($urandom_range(0, 65535));
            send_access($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, addr);
         end
      end
      steady = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_direct_mapped_defaults();
      test_lru_four_ways();
      test_clamped_settings();
      test_geometry_change();
      test_random_phases();

      drain_trace();
      repeat (10) @(posedge clock);

      $display("Covered %0d accesses and %0d trace records over %0d register writes.",
               accesses_sent, records_seen, csr_writes);
      $display("Mismatches: %0d, records still owed: %0d.", mismatch_count, trace_queue.size());
      if (mismatch_count == 0 && trace_queue.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run (long gaps and stalls on
   // every access and every record).
   initial begin
      #5_000_000;
      $display("Timed out with %0d records still owed.", trace_queue.size());
      $display("FAIL");
      $finish;
   end

endmodule
